// ===== rtl/fsc_pkg.sv =====
// Shared types, codes and constants of the fan stage controller.
package fsc_pkg;

  localparam int TEMP_W      = 11;
  localparam int THR_W       = 7;
  localparam int NUM_PLATES  = 4;
  localparam int LEVEL_MAX   = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam logic [THR_W-1:0] HOT_THR_RST = 7'd60;

  // Plate mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_KEEP  = 2'd1;
  localparam logic [1:0] MODE_LATCH = 2'd2;

  // Fault codes
  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_SENSOR_MIN = 3'd1;
  localparam logic [2:0] FAULT_SENSOR_MAX = 3'd4;
  localparam logic [2:0] FAULT_PINS       = 3'd5;

  // Feedback pin patterns
  localparam logic [2:0] PINS_STAGE0 = 3'b000;
  localparam logic [2:0] PINS_STAGE1 = 3'b001;
  localparam logic [2:0] PINS_STAGE2 = 3'b010;
  localparam logic [2:0] PINS_STAGE3 = 3'b100;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DN   = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    LAMP_KEEP  = 2'd0,
    LAMP_OFF   = 2'd1,
    LAMP_GREEN = 2'd2,
    LAMP_RED   = 2'd3
  } lamp_t;

  // Input transaction, lowest member last (matches tdata packing)
  typedef struct packed {
    logic [2:0]                              stage_pins;
    logic [2:0]                              sensor_fault;
    logic [NUM_PLATES-1:0][1:0]              plate_mode;
    logic [NUM_PLATES-1:0][TEMP_W-1:0]       temp;
  } fsc_in_t;

  // Result transaction, lowest member last (matches tdata packing)
  typedef struct packed {
    logic [1:0] demand_level;
    logic       fault_flash;
    logic [2:0] fault_code;
    lamp_t      lamp_cmd;
    step_t      step_pulse;
  } fsc_res_t;

  // Demand evaluation result handed to the stage logic and latch register
  typedef struct packed {
    logic [1:0]            level;
    logic [NUM_PLATES-1:0] latch_nxt;
  } fsc_dem_t;

endpackage

// ===== rtl/fsc_demand.sv =====
// Demand level and plate latch update for one transaction.
module fsc_demand (
  input  fsc_pkg::fsc_in_t                 item,
  input  logic [fsc_pkg::THR_W-1:0]        hot_thr,
  input  logic [fsc_pkg::NUM_PLATES-1:0]   latch_r,
  output fsc_pkg::fsc_dem_t                dem
);
  import fsc_pkg::*;

  logic [NUM_PLATES-1:0] counts;
  logic [NUM_PLATES-1:0] latch_new;
  logic [2:0]            sum;
  logic                  sens_fault;

  always_comb begin
    logic signed [TEMP_W-4:0] scaled;
    logic                     hot;
    counts    = '0;
    latch_new = latch_r;
    for (int i = 0; i < NUM_PLATES; i++) begin
      // Drop the three low bits of the two's complement reading: floor division by 8
      scaled = $signed(item.temp[i][TEMP_W-1:3]);
      hot    = scaled > $signed({1'b0, hot_thr});
      counts[i] = hot
               || (item.plate_mode[i] == MODE_KEEP && latch_r[i])
               || (item.plate_mode[i] == MODE_LATCH);
      if (!hot && item.plate_mode[i] == MODE_LATCH) begin
        latch_new[i] = 1'b1;
      end
      if (item.plate_mode[i] == MODE_OFF) begin
        latch_new[i] = 1'b0;
      end
    end
  end

  assign sum = 3'(counts[0]) + 3'(counts[1]) + 3'(counts[2]) + 3'(counts[3]);

  assign sens_fault = item.sensor_fault inside {[FAULT_SENSOR_MIN:FAULT_SENSOR_MAX]};

  // Hold latches and report no demand on a sensor fault
  always_comb begin
    if (sens_fault) begin
      dem.level     = 2'd0;
      dem.latch_nxt = latch_r;
    end else begin
      dem.level     = (sum > 3'(LEVEL_MAX)) ? 2'(LEVEL_MAX) : sum[1:0];
      dem.latch_nxt = latch_new;
    end
  end

endmodule

// ===== rtl/fsc_step.sv =====
// Fault check, feedback compare and stage step decision.
module fsc_step (
  input  logic [2:0]         sensor_fault,
  input  logic [2:0]         stage_pins,
  input  logic [1:0]         level,
  input  logic [1:0]         stage_r,
  output fsc_pkg::fsc_res_t  res,
  output logic [1:0]         stage_nxt
);
  import fsc_pkg::*;

  logic [1:0] actual;
  logic       pins_bad;
  logic       sens_fault;

  always_comb begin
    pins_bad = 1'b0;
    case (stage_pins)
      PINS_STAGE0: actual = 2'd0;
      PINS_STAGE1: actual = 2'd1;
      PINS_STAGE2: actual = 2'd2;
      PINS_STAGE3: actual = 2'd3;
      default: begin
        actual   = 2'd0;
        pins_bad = 1'b1;
      end
    endcase
  end

  assign sens_fault = sensor_fault inside {[FAULT_SENSOR_MIN:FAULT_SENSOR_MAX]};

  always_comb begin
    res.demand_level = level;
    res.fault_flash  = 1'b0;
    res.fault_code   = FAULT_NONE;
    res.lamp_cmd     = LAMP_KEEP;
    res.step_pulse   = STEP_NONE;
    stage_nxt        = stage_r;
    if (pins_bad) begin
      res.fault_code  = FAULT_PINS;
      res.fault_flash = 1'b1;
    end else if (sens_fault) begin
      res.fault_code  = sensor_fault;
      res.fault_flash = 1'b1;
    end else if (actual != stage_r) begin
      // Fan stopped on its own with nothing demanded: resync to off
      if (actual == 2'd0 && level == 2'd0) begin
        stage_nxt    = 2'd0;
        res.lamp_cmd = LAMP_OFF;
      end else begin
        res.lamp_cmd = LAMP_RED;
      end
    end else if (level > stage_r) begin
      res.step_pulse = STEP_UP;
      if (stage_r == 2'd0) begin
        res.lamp_cmd = LAMP_GREEN;
      end
      stage_nxt = stage_r + 2'd1;
    end else if (level < stage_r) begin
      res.step_pulse = STEP_DN;
      stage_nxt      = stage_r - 2'd1;
    end else if (stage_r == 2'd0) begin
      res.lamp_cmd = LAMP_OFF;
    end
  end

endmodule

// ===== rtl/fan_stage_controller.sv =====
// Top level of the fan stage controller: handshakes, state and result register.
//
// Usage:
//   in_*  : one transaction per controller tick carrying four temperature
//           readings, four plate modes, the sensor fault code and the fan
//           feedback pins. It is captured in an input register.
//   out_* : one command per input transaction (step pulse, lamp command,
//           fault code, fault flash, demand level), held in a result register.
//   cfg_* : write hot_threshold with cfg_we/cfg_wdata; write only while idle.
// Path: an accepted transaction waits in the input register until the result
//   register frees up. Throughput: one transaction per cycle while out_tready
//   is high. The demand adder/compare and stage decision sit between the input
//   and result registers; the commanded stage and plate latches update as a
//   transaction enters the result register, so the next one sees them at once.
// Reset: rst_n low clears both registers' valid flags, the commanded stage
//   and plate latches, and loads hot_threshold with 60.
// Stall: with out_tready low the result holds; one more transaction can wait
//   in the input register, after which in_tready drops.
module fan_stage_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata fields, low bit up: temp_a[10:0], temp_b[21:11], temp_c[32:22],
  // temp_d[43:33], plate_mode_a[45:44], plate_mode_b[47:46],
  // plate_mode_c[49:48], plate_mode_d[51:50], sensor_fault[54:52],
  // stage_pins[57:55], unused [63:58]
  input  logic [fsc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata fields, low bit up: step_pulse[1:0], lamp_cmd[3:2],
  // fault_code[6:4], fault_flash[7], demand_level[9:8], zero fill [15:10]
  output logic [fsc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [fsc_pkg::THR_W-1:0]          cfg_wdata
);
  import fsc_pkg::*;

  fsc_in_t                in_data_r;
  logic                   in_vld_r;
  fsc_res_t               res_r;
  logic                   out_vld_r;
  logic [THR_W-1:0]       thr_r;
  logic [1:0]             stage_r;
  logic [1:0]             stage_nxt;
  logic [NUM_PLATES-1:0]  latch_r;

  fsc_dem_t               dem;
  fsc_res_t               res_nxt;
  logic                   res_adv;
  logic                   res_load;
  logic                   in_acc;

  // Result register frees up when empty or being taken this cycle
  assign res_adv   = !out_vld_r || out_tready;
  assign res_load  = in_vld_r && res_adv;
  assign in_tready = !in_vld_r || res_adv;
  assign in_acc    = in_tvalid && in_tready;

  fsc_demand u_demand (
    .item    (in_data_r),
    .hot_thr (thr_r),
    .latch_r (latch_r),
    .dem     (dem)
  );

  fsc_step u_step (
    .sensor_fault (in_data_r.sensor_fault),
    .stage_pins   (in_data_r.stage_pins),
    .level        (dem.level),
    .stage_r      (stage_r),
    .res          (res_nxt),
    .stage_nxt    (stage_nxt)
  );

  // Input register: load on accept, drop once passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (res_load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= fsc_in_t'(in_tdata[$bits(fsc_in_t)-1:0]);
    end
  end

  // Result register and controller state advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      stage_r   <= 2'd0;
      latch_r   <= '0;
    end else if (res_load) begin
      out_vld_r <= 1'b1;
      stage_r   <= stage_nxt;
      latch_r   <= dem.latch_nxt;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= HOT_THR_RST;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(fsc_res_t))'(0), res_r};

  // State moves only when a transaction passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !res_load |=> $stable(stage_r) && $stable(latch_r))
    else $error("controller state changed without a transaction");

  // A step up command advances the commanded stage by exactly one
  a_step_up: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res_nxt.step_pulse == STEP_UP |=> stage_r == $past(stage_r) + 2'd1)
    else $error("step up did not advance the commanded stage");

  // A step down command lowers the commanded stage by exactly one
  a_step_dn: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res_nxt.step_pulse == STEP_DN |=> stage_r == $past(stage_r) - 2'd1)
    else $error("step down did not lower the commanded stage");

  // Flash accompanies every fault code, and faults never step the fan
  a_fault_flash: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.fault_flash == (res_r.fault_code != FAULT_NONE))
                  && (!res_r.fault_flash || res_r.step_pulse == STEP_NONE))
    else $error("fault flash inconsistent with fault code");

  // A sensor fault leaves the plate latches untouched
  a_fault_latch: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && in_data_r.sensor_fault >= FAULT_SENSOR_MIN
             && in_data_r.sensor_fault <= FAULT_SENSOR_MAX |=> $stable(latch_r))
    else $error("plate latches changed on a sensor fault");

endmodule
